>>> rtl/core/hmac_tagged_frame_checker_core_macros.svh
// Assertion macros shared by the frame checker RTL.
`ifndef HMAC_TAGGED_FRAME_CHECKER_CORE_MACROS_SVH
`define HMAC_TAGGED_FRAME_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define HTFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frame checker assertion failed");
// Expression that must never be true outside reset.
`define HTFC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("frame checker forbidden condition");
`else
`define HTFC_ASSERT(lbl, prop)
`define HTFC_ASSERT_NEVER(lbl, expr)
`endif

`endif

>>> rtl/core/htfc_pkg.sv
// Shared types, constants and SHA-256 helpers of the frame checker.
`default_nettype none

package htfc_pkg;

  localparam int unsigned TAG_BYTES_DEF = 8;
  localparam int unsigned HDR_BYTES     = 8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_VERSION  = 3'd0,
    CFG_ID_LIMIT = 3'd1,
    CFG_PAY_LIMIT = 3'd2,
    CFG_KEY_LEN  = 3'd3,
    CFG_KEY_W0   = 3'd4,
    CFG_KEY_W1   = 3'd5,
    CFG_KEY_W2   = 3'd6,
    CFG_KEY_W3   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_IDLEN = 3'd1,
    PH_ID    = 3'd2,
    PH_PLEN  = 3'd3,
    PH_PAY   = 3'd4,
    PH_TAG   = 3'd5,
    PH_SKIP  = 3'd6
  } parse_phase_e;

  typedef enum logic [2:0] {
    ROLE_HDR  = 3'd0,
    ROLE_ID   = 3'd1,
    ROLE_PAY  = 3'd2,
    ROLE_TAG  = 3'd3,
    ROLE_SKIP = 3'd4
  } byte_role_e;

  typedef enum logic [2:0] {
    VD_OK       = 3'd0,
    VD_SHORT    = 3'd1,
    VD_VERSION  = 3'd2,
    VD_ID_LONG  = 3'd3,
    VD_PAY_LONG = 3'd4,
    VD_LENGTH   = 3'd5,
    VD_TAG      = 3'd6
  } verdict_e;

  // Source of a byte pushed into the SHA block buffer
  typedef enum logic [2:0] {
    SRC_MSG  = 3'd0,
    SRC_IPAD = 3'd1,
    SRC_OPAD = 3'd2,
    SRC_80   = 3'd3,
    SRC_ZERO = 3'd4,
    SRC_LEN  = 3'd5,
    SRC_DIG  = 3'd6
  } feed_src_e;

  typedef enum logic [3:0] {
    CS_IDLE   = 4'd0,
    CS_KEYI   = 4'd1,
    CS_PARSE  = 4'd2,
    CS_DECIDE = 4'd3,
    CS_PAD80  = 4'd4,
    CS_PADZ   = 4'd5,
    CS_LEN    = 4'd6,
    CS_OINIT  = 4'd7,
    CS_OKEY   = 4'd8,
    CS_ODIG   = 4'd9,
    CS_CINIT  = 4'd10,
    CS_CRND   = 4'd11,
    CS_CADD   = 4'd12,
    CS_EMIT   = 4'd13
  } ctl_state_e;

  typedef struct packed {
    logic [7:0]   version;
    logic [7:0]   id_limit;
    logic [7:0]   pay_limit;
    logic [5:0]   key_len;
    logic [255:0] key;
  } htfc_cfg_t;

  typedef struct packed {
    logic      take;
    logic      parse;
    logic      feed;
    feed_src_e src;
    logic      cinit;
    logic      round;
    logic      cadd;
    logic      oinit;
    logic      emit;
    logic      outer;
    logic [5:0] cnt;
  } htfc_cmd_t;

  typedef struct packed {
    logic frame_start;
    logic absorb;
    logic pos_last;
    logic pos_pad;
    logic need_hash;
  } htfc_status_t;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hmac_tagged_frame_checker_core.sv
// Top level of the HMAC-SHA256 tagged frame checker: config registers and wiring.
//
//   channel   direction  handshake                 content
//   in        request    in_valid_i / in_stall_o   frame_byte_i, frame_last_i
//   out       result     out_valid_o / out_stall_i role, echo, verdict, header fields
//   cfg       write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request at a time. A plain byte passes through accept, parse, decide and result,
// plus a compression for each 64-byte block that fills (one SHA-256 round per cycle).
// The first byte of a frame adds the feed and the compression of the inner key block;
// the final byte of a good-length frame adds padding, the outer key block, the digest
// bytes and three or four compressions. The result sits in an output register; stalls
// there hold the next result only.
// Reset loads the configuration defaults and clears the frame state.
`default_nettype none
`include "hmac_tagged_frame_checker_core_macros.svh"

module hmac_tagged_frame_checker_core #(
  parameter int unsigned TagBytes = htfc_pkg::TAG_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       byte_role_o,
  output logic [7:0]       echo_byte_o,
  output logic             frame_done_o,
  output logic [2:0]       verdict_o,
  output logic [7:0]       message_type_o,
  output logic [31:0]      sequence_number_o,
  output logic [7:0]       sender_id_length_o,
  output logic [7:0]       body_length_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  htfc_pkg::htfc_cfg_t    cfg_q;
  htfc_pkg::htfc_cmd_t    cmd;
  htfc_pkg::htfc_status_t status;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version   <= 8'd1;
      cfg_q.id_limit  <= 8'd32;
      cfg_q.pay_limit <= 8'd200;
      cfg_q.key_len   <= 6'd32;
      cfg_q.key       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        htfc_pkg::CFG_VERSION:   cfg_q.version   <= cfg_data_i[7:0];
        htfc_pkg::CFG_ID_LIMIT:  cfg_q.id_limit  <= cfg_data_i[7:0];
        htfc_pkg::CFG_PAY_LIMIT: cfg_q.pay_limit <= cfg_data_i[7:0];
        htfc_pkg::CFG_KEY_LEN:   cfg_q.key_len   <= cfg_data_i[5:0];
        htfc_pkg::CFG_KEY_W0:    cfg_q.key[255:192] <= cfg_data_i;
        htfc_pkg::CFG_KEY_W1:    cfg_q.key[191:128] <= cfg_data_i;
        htfc_pkg::CFG_KEY_W2:    cfg_q.key[127:64]  <= cfg_data_i;
        default:                 cfg_q.key[63:0]    <= cfg_data_i;
      endcase
    end
  end

  htfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  htfc_datapath #(
    .TagBytes (TagBytes)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .frame_byte_i       (frame_byte_i),
    .frame_last_i       (frame_last_i),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .status_o           (status),
    .byte_role_o        (byte_role_o),
    .echo_byte_o        (echo_byte_o),
    .frame_done_o       (frame_done_o),
    .verdict_o          (verdict_o),
    .message_type_o     (message_type_o),
    .sequence_number_o  (sequence_number_o),
    .sender_id_length_o (sender_id_length_o),
    .body_length_o      (body_length_o)
  );

  // One request in flight: an accepted byte blocks the input on the next cycle
  `HTFC_ASSERT(a_one_in_flight, in_valid_i && !in_stall_o |=> in_stall_o)
  // Only a final byte carries a verdict
  `HTFC_ASSERT_NEVER(a_verdict_only_done, out_valid_o && !frame_done_o && verdict_o != htfc_pkg::VD_OK)
  // Result is never produced while the controller still owes a pending result
  `HTFC_ASSERT_NEVER(a_emit_blocked, cmd.emit && out_valid_o && out_stall_i)

endmodule

`default_nettype wire

>>> rtl/core/htfc_datapath.sv
// Datapath: frame parser, SHA-256 block buffer and round unit, verdict output.
`default_nettype none

module htfc_datapath #(
  parameter int unsigned TagBytes = htfc_pkg::TAG_BYTES_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [7:0]              frame_byte_i,
  input  wire logic                    frame_last_i,
  input  wire htfc_pkg::htfc_cfg_t     cfg_i,
  input  wire htfc_pkg::htfc_cmd_t     cmd_i,
  output htfc_pkg::htfc_status_t       status_o,
  output logic [2:0]                   byte_role_o,
  output logic [7:0]                   echo_byte_o,
  output logic                         frame_done_o,
  output logic [2:0]                   verdict_o,
  output logic [7:0]                   message_type_o,
  output logic [31:0]                  sequence_number_o,
  output logic [7:0]                   sender_id_length_o,
  output logic [7:0]                   body_length_o
);

  localparam int unsigned MinFrame = htfc_pkg::HDR_BYTES + TagBytes;
  localparam int unsigned FcW      = $clog2(MinFrame + 1);
  localparam int unsigned TagW     = 8 * TagBytes;

  // Received byte and frame parse state
  logic [7:0]              byte_q;
  logic                    last_q;
  htfc_pkg::parse_phase_e  phase_q, phase_n;
  logic [8:0]              fpos_q, fpos_n;
  logic [7:0]              idlen_q, idlen_n, plen_q, plen_n, type_q, type_n;
  logic [31:0]             seq_q, seq_n;
  logic [1:0]              seq_sel;
  htfc_pkg::verdict_e      err_q, err_n;
  htfc_pkg::byte_role_e    role_q, role_n;
  logic                    tag_done_q, tag_done_n;
  logic                    tag_store, absorb;
  logic [TagW-1:0]         tag_q;
  logic [FcW-1:0]          fcnt_q;
  logic [15:0]             msg_bits_q;

  // SHA-256 state
  logic [511:0]            w_q;
  logic [255:0]            h_q, dig_q;
  logic [31:0]             a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
  logic [5:0]              pos_q;

  logic [7:0]              feed_byte, key_b, len_b;
  logic [63:0]             len_bits;
  logic [5:0]              key_clip;
  logic [31:0]             t1, t2, w_new;
  htfc_pkg::verdict_e      verdict_n;

  // Frame parser
  always_comb begin
    phase_n    = phase_q;
    fpos_n     = fpos_q;
    idlen_n    = idlen_q;
    plen_n     = plen_q;
    type_n     = type_q;
    seq_n      = seq_q;
    err_n      = err_q;
    tag_done_n = tag_done_q;
    role_n     = htfc_pkg::ROLE_SKIP;
    absorb     = 1'b0;
    tag_store  = 1'b0;
    // sequence bytes 2..5 land in byte lanes 0..3
    seq_sel    = fpos_q[1:0] - 2'd2;
    case (phase_q)
      htfc_pkg::PH_HDR: begin
        role_n = htfc_pkg::ROLE_HDR;
        absorb = 1'b1;
        if (fpos_q == 9'd0) begin
          if (byte_q != cfg_i.version) err_n = htfc_pkg::VD_VERSION;
        end else if (fpos_q == 9'd1) begin
          type_n = byte_q;
        end else begin
          seq_n[{seq_sel, 3'b000} +: 8] = byte_q;
        end
        fpos_n = fpos_q + 9'd1;
        if (fpos_n >= 9'd6) begin
          phase_n = htfc_pkg::PH_IDLEN;
          fpos_n  = 9'd0;
        end
      end
      htfc_pkg::PH_IDLEN: begin
        role_n  = htfc_pkg::ROLE_HDR;
        absorb  = 1'b1;
        idlen_n = byte_q;
        if (byte_q > cfg_i.id_limit) err_n = htfc_pkg::VD_ID_LONG;
        else phase_n = (byte_q != 8'd0) ? htfc_pkg::PH_ID : htfc_pkg::PH_PLEN;
      end
      htfc_pkg::PH_ID: begin
        role_n = htfc_pkg::ROLE_ID;
        absorb = 1'b1;
        fpos_n = fpos_q + 9'd1;
        if (fpos_n >= {1'b0, idlen_q}) begin
          phase_n = htfc_pkg::PH_PLEN;
          fpos_n  = 9'd0;
        end
      end
      htfc_pkg::PH_PLEN: begin
        role_n = htfc_pkg::ROLE_HDR;
        absorb = 1'b1;
        plen_n = byte_q;
        if (byte_q > cfg_i.pay_limit) err_n = htfc_pkg::VD_PAY_LONG;
        else phase_n = (byte_q != 8'd0) ? htfc_pkg::PH_PAY : htfc_pkg::PH_TAG;
      end
      htfc_pkg::PH_PAY: begin
        role_n = htfc_pkg::ROLE_PAY;
        absorb = 1'b1;
        fpos_n = fpos_q + 9'd1;
        if (fpos_n >= {1'b0, plen_q}) begin
          phase_n = htfc_pkg::PH_TAG;
          fpos_n  = 9'd0;
        end
      end
      htfc_pkg::PH_TAG: begin
        role_n    = htfc_pkg::ROLE_TAG;
        tag_store = 1'b1;
        fpos_n    = fpos_q + 9'd1;
        if (fpos_n >= 9'(TagBytes)) begin
          if (last_q) tag_done_n = 1'b1;
          else err_n = htfc_pkg::VD_LENGTH;
        end
      end
      default: begin
        role_n = htfc_pkg::ROLE_SKIP;
      end
    endcase
    if (err_n != htfc_pkg::VD_OK) phase_n = htfc_pkg::PH_SKIP;
  end

  // Byte source for the block buffer
  always_comb begin
    key_clip = (cfg_i.key_len > 6'd32) ? 6'd32 : cfg_i.key_len;
    key_b    = (cmd_i.cnt < key_clip) ? cfg_i.key[8*(5'd31 - cmd_i.cnt[4:0]) +: 8] : 8'd0;
    len_bits = cmd_i.outer ? 64'd768 : {48'd0, msg_bits_q};
    len_b    = len_bits[8*(3'd7 - cmd_i.cnt[2:0]) +: 8];
    case (cmd_i.src)
      htfc_pkg::SRC_MSG:  feed_byte = byte_q;
      htfc_pkg::SRC_IPAD: feed_byte = key_b ^ 8'h36;
      htfc_pkg::SRC_OPAD: feed_byte = key_b ^ 8'h5c;
      htfc_pkg::SRC_80:   feed_byte = 8'h80;
      htfc_pkg::SRC_LEN:  feed_byte = len_b;
      htfc_pkg::SRC_DIG:  feed_byte = dig_q[255:248];
      default:            feed_byte = 8'h00;
    endcase
  end

  // SHA-256 round and message schedule; w_q holds the oldest word on top
  always_comb begin
    t1 = hh_q + htfc_pkg::big_s1(e_q) + ((e_q & f_q) ^ (~e_q & g_q))
       + htfc_pkg::sha_k(cmd_i.cnt) + w_q[511:480];
    t2 = htfc_pkg::big_s0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
    w_new = w_q[511:480] + htfc_pkg::small_s0(w_q[479:448]) + w_q[223:192]
          + htfc_pkg::small_s1(w_q[63:32]);
  end

  // Verdict of a finished frame
  always_comb begin
    if (fcnt_q < FcW'(MinFrame))            verdict_n = htfc_pkg::VD_SHORT;
    else if (err_q != htfc_pkg::VD_OK)      verdict_n = err_q;
    else if (!tag_done_q)                   verdict_n = htfc_pkg::VD_LENGTH;
    else if (h_q[255 -: TagW] == tag_q)     verdict_n = htfc_pkg::VD_OK;
    else                                    verdict_n = htfc_pkg::VD_TAG;
  end

  always_comb begin
    status_o.frame_start = (fcnt_q == '0);
    status_o.absorb      = absorb;
    status_o.pos_last    = (pos_q == 6'd63);
    status_o.pos_pad     = (pos_q == 6'd56);
    status_o.need_hash   = last_q && (fcnt_q >= FcW'(MinFrame))
                         && (err_q == htfc_pkg::VD_OK) && tag_done_q;
  end

  // Control and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= htfc_pkg::PH_HDR;
      fpos_q     <= '0;
      idlen_q    <= '0;
      plen_q     <= '0;
      type_q     <= '0;
      seq_q      <= '0;
      err_q      <= htfc_pkg::VD_OK;
      role_q     <= htfc_pkg::ROLE_HDR;
      tag_done_q <= 1'b0;
      tag_q      <= '0;
      fcnt_q     <= '0;
      msg_bits_q <= '0;
      pos_q      <= '0;
      h_q        <= htfc_pkg::SHA_IV;
    end else begin
      if (cmd_i.take) begin
        if (fcnt_q < FcW'(MinFrame)) fcnt_q <= fcnt_q + FcW'(1);
        if (fcnt_q == '0) msg_bits_q <= 16'd512;
      end
      if (cmd_i.parse) begin
        phase_q    <= phase_n;
        fpos_q     <= fpos_n;
        idlen_q    <= idlen_n;
        plen_q     <= plen_n;
        type_q     <= type_n;
        seq_q      <= seq_n;
        err_q      <= err_n;
        role_q     <= role_n;
        tag_done_q <= tag_done_n;
        if (tag_store) tag_q <= {tag_q[TagW-1:0] << 8} | {{(TagW-8){1'b0}}, byte_q};
        if (absorb) msg_bits_q <= msg_bits_q + 16'd8;
      end
      if (cmd_i.feed) pos_q <= pos_q + 6'd1;
      if (cmd_i.oinit) h_q <= htfc_pkg::SHA_IV;
      if (cmd_i.cadd) begin
        h_q <= {h_q[255:224] + a_q, h_q[223:192] + b_q, h_q[191:160] + c_q,
                h_q[159:128] + d_q, h_q[127:96] + e_q, h_q[95:64] + f_q,
                h_q[63:32] + g_q, h_q[31:0] + hh_q};
      end
      if (cmd_i.emit && last_q) begin
        phase_q    <= htfc_pkg::PH_HDR;
        fpos_q     <= '0;
        idlen_q    <= '0;
        plen_q     <= '0;
        type_q     <= '0;
        seq_q      <= '0;
        err_q      <= htfc_pkg::VD_OK;
        tag_done_q <= 1'b0;
        tag_q      <= '0;
        fcnt_q     <= '0;
        msg_bits_q <= '0;
        pos_q      <= '0;
        h_q        <= htfc_pkg::SHA_IV;
      end
    end
  end

  // Payload registers: byte latch, block buffer, working variables, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q <= frame_byte_i;
      last_q <= frame_last_i;
    end
    if (cmd_i.feed) w_q <= {w_q[503:0], feed_byte};
    else if (cmd_i.round) w_q <= {w_q[479:0], w_new};
    if (cmd_i.oinit) dig_q <= h_q;
    else if (cmd_i.feed && (cmd_i.src == htfc_pkg::SRC_DIG)) dig_q <= {dig_q[247:0], 8'h00};
    if (cmd_i.cinit) begin
      {a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q} <= h_q;
    end else if (cmd_i.round) begin
      hh_q <= g_q;
      g_q  <= f_q;
      f_q  <= e_q;
      e_q  <= d_q + t1;
      d_q  <= c_q;
      c_q  <= b_q;
      b_q  <= a_q;
      a_q  <= t1 + t2;
    end
    if (cmd_i.emit) begin
      byte_role_o        <= role_q;
      echo_byte_o        <= byte_q;
      frame_done_o       <= last_q;
      verdict_o          <= last_q ? verdict_n : htfc_pkg::VD_OK;
      message_type_o     <= last_q ? type_q : 8'd0;
      sequence_number_o  <= last_q ? seq_q : 32'd0;
      sender_id_length_o <= last_q ? idlen_q : 8'd0;
      body_length_o      <= last_q ? plen_q : 8'd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/htfc_ctrl.sv
// Controller: sequences parsing, key blocks, padding, compression and result.
`default_nettype none

module htfc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  input  wire htfc_pkg::htfc_status_t status_i,
  output htfc_pkg::htfc_cmd_t        cmd_o
);

  htfc_pkg::ctl_state_e state_q, state_d, ret_q, ret_d;
  logic [5:0]           cnt_q, cnt_d;
  logic                 outer_q, outer_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    outer_d     = outer_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      htfc_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = '0;
          state_d = status_i.frame_start ? htfc_pkg::CS_KEYI : htfc_pkg::CS_PARSE;
        end
      end
      htfc_pkg::CS_KEYI: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = htfc_pkg::CS_CINIT;
          ret_d   = htfc_pkg::CS_PARSE;
        end
      end
      htfc_pkg::CS_PARSE: begin
        state_d = htfc_pkg::CS_DECIDE;
        if (status_i.absorb && status_i.pos_last) begin
          state_d = htfc_pkg::CS_CINIT;
          ret_d   = htfc_pkg::CS_DECIDE;
        end
      end
      htfc_pkg::CS_DECIDE: begin
        outer_d = 1'b0;
        state_d = status_i.need_hash ? htfc_pkg::CS_PAD80 : htfc_pkg::CS_EMIT;
      end
      htfc_pkg::CS_PAD80: begin
        state_d = htfc_pkg::CS_PADZ;
        if (status_i.pos_last) begin
          state_d = htfc_pkg::CS_CINIT;
          ret_d   = htfc_pkg::CS_PADZ;
        end
      end
      htfc_pkg::CS_PADZ: begin
        if (status_i.pos_pad) begin
          cnt_d   = '0;
          state_d = htfc_pkg::CS_LEN;
        end else if (status_i.pos_last) begin
          state_d = htfc_pkg::CS_CINIT;
          ret_d   = htfc_pkg::CS_PADZ;
        end
      end
      htfc_pkg::CS_LEN: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd7) begin
          state_d = htfc_pkg::CS_CINIT;
          ret_d   = outer_q ? htfc_pkg::CS_EMIT : htfc_pkg::CS_OINIT;
        end
      end
      htfc_pkg::CS_OINIT: begin
        cnt_d   = '0;
        outer_d = 1'b1;
        state_d = htfc_pkg::CS_OKEY;
      end
      htfc_pkg::CS_OKEY: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = htfc_pkg::CS_CINIT;
          ret_d   = htfc_pkg::CS_ODIG;
        end
      end
      htfc_pkg::CS_ODIG: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) state_d = htfc_pkg::CS_PAD80;
      end
      htfc_pkg::CS_CINIT: begin
        cnt_d   = '0;
        state_d = htfc_pkg::CS_CRND;
      end
      htfc_pkg::CS_CRND: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = htfc_pkg::CS_CADD;
      end
      htfc_pkg::CS_CADD: begin
        cnt_d   = '0;
        state_d = ret_q;
      end
      htfc_pkg::CS_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          outer_d     = 1'b0;
          state_d     = htfc_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = htfc_pkg::CS_IDLE;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.src   = htfc_pkg::SRC_MSG;
    cmd_o.cnt   = cnt_q;
    cmd_o.outer = outer_q;
    in_stall_o  = (state_q != htfc_pkg::CS_IDLE);
    case (state_q)
      htfc_pkg::CS_IDLE:   cmd_o.take = in_valid_i;
      htfc_pkg::CS_KEYI: begin
        cmd_o.feed = 1'b1;
        cmd_o.src  = htfc_pkg::SRC_IPAD;
      end
      htfc_pkg::CS_PARSE: begin
        cmd_o.parse = 1'b1;
        cmd_o.feed  = status_i.absorb;
      end
      htfc_pkg::CS_PAD80: begin
        cmd_o.feed = 1'b1;
        cmd_o.src  = htfc_pkg::SRC_80;
      end
      htfc_pkg::CS_PADZ: begin
        cmd_o.feed = !status_i.pos_pad;
        cmd_o.src  = htfc_pkg::SRC_ZERO;
      end
      htfc_pkg::CS_LEN: begin
        cmd_o.feed = 1'b1;
        cmd_o.src  = htfc_pkg::SRC_LEN;
      end
      htfc_pkg::CS_OINIT:  cmd_o.oinit = 1'b1;
      htfc_pkg::CS_OKEY: begin
        cmd_o.feed = 1'b1;
        cmd_o.src  = htfc_pkg::SRC_OPAD;
      end
      htfc_pkg::CS_ODIG: begin
        cmd_o.feed = 1'b1;
        cmd_o.src  = htfc_pkg::SRC_DIG;
      end
      htfc_pkg::CS_CINIT:  cmd_o.cinit = 1'b1;
      htfc_pkg::CS_CRND:   cmd_o.round = 1'b1;
      htfc_pkg::CS_CADD:   cmd_o.cadd = 1'b1;
      htfc_pkg::CS_EMIT:   cmd_o.emit = out_free;
      default: begin
        cmd_o.take = 1'b0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htfc_pkg::CS_IDLE;
      ret_q       <= htfc_pkg::CS_IDLE;
      cnt_q       <= '0;
      outer_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      outer_q     <= outer_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
